### src/syn_scan_window_detector_defines.svh
// Assertion macros used by the SYN-scan detector datapath.
`ifndef SYN_SCAN_WINDOW_DETECTOR_DEFINES_SVH
`define SYN_SCAN_WINDOW_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssw assertion failed");

`endif

### src/ssw_pkg.sv
// Types and constants shared by the SYN-scan window detector.
package ssw_pkg;

  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] WINDOW_RESET = 16'd60;
  localparam logic [15:0] THRESH_RESET = 16'd20;

  // Entries examined per scan cycle, and the bits of an index within a group.
  localparam int SCAN_GROUP = 8;
  localparam int SCAN_IDX_W = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CALC,
    S_UPDATE
  } state_t;

  // Per-entry fields kept in RAM.
  typedef struct packed {
    logic [31:0] window_start;
    logic [15:0] count;
    logic        alerted;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic rd_en;
    logic calc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_ignore;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

### src/ssw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/ssw_ctrl.sv
// Controller state machine for the SYN-scan window detector.
module ssw_ctrl import ssw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.in_ignore ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_READ;
        end
      end
      S_READ:   state_nxt = S_CALC;
      S_CALC:   state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_READ:   cmd.rd_en     = 1'b1;
      S_CALC:   cmd.calc      = 1'b1;
      S_UPDATE: cmd.commit    = stat.out_free;
      default:  cmd           = '0;
    endcase
  end

endmodule

### src/ssw_dp.sv
// Datapath: source table, group scan, window update and result register.
`include "syn_scan_window_detector_defines.svh"
module ssw_dp import ssw_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [31:0]          in_src_addr,
  input  logic [7:0]           in_tcp_flags,
  input  logic [31:0]          in_now_seconds,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_scan_alert,
  output logic [15:0]          out_burst_count,
  output logic [5:0]           out_table_slot,
  output logic                 out_evicted,
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int SW   = $clog2(TABLE_ENTRIES);
  localparam int NGRP = (TABLE_ENTRIES + SCAN_GROUP - 1) / SCAN_GROUP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW = NGRP * SCAN_GROUP;

  // Configuration
  logic [15:0] win_r, thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
      thr_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WINDOW: win_r <= cfg_data;
        CFG_THRESH: thr_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Address table: one comparator per entry
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              addr_r [TABLE_ENTRIES];
  logic [PADW-1:0]          hit_vec, free_vec;

  always_comb begin
    hit_vec  = '0;
    free_vec = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]  = valid_r[i] && (addr_r[i] == in_src_addr);
      free_vec[i] = !valid_r[i];
    end
  end

  // Captured item
  logic [31:0]     src_r, now_r;
  logic            ignore_r;
  logic [PADW-1:0] hit_vec_r, free_vec_r;
  logic            in_ignore;

  assign in_ignore = !in_tcp_flags[FLAG_SYN_BIT] || in_tcp_flags[FLAG_ACK_BIT];

  // Group scan
  logic [GW-1:0]         grp_r;
  logic                  free_seen_r;
  logic [SW-1:0]         free_slot_r, slot_r;
  logic                  hit_r, evict_r;
  logic [SCAN_GROUP-1:0] grp_hit, grp_free;
  logic                  grp_hit_found, grp_free_found;
  logic [SCAN_IDX_W-1:0] grp_hit_idx, grp_free_idx;
  logic [GW+SCAN_IDX_W-1:0] hit_cat, free_cat;
  logic                  scan_end;

  assign grp_hit  = hit_vec_r[grp_r*SCAN_GROUP +: SCAN_GROUP];
  assign grp_free = free_vec_r[grp_r*SCAN_GROUP +: SCAN_GROUP];

  // Lowest set bit in the group wins.
  always_comb begin
    grp_hit_found  = 1'b0;
    grp_free_found = 1'b0;
    grp_hit_idx    = '0;
    grp_free_idx   = '0;
    for (int i = SCAN_GROUP - 1; i >= 0; i--) begin
      if (grp_hit[i]) begin
        grp_hit_found = 1'b1;
        grp_hit_idx   = SCAN_IDX_W'(i);
      end
      if (grp_free[i]) begin
        grp_free_found = 1'b1;
        grp_free_idx   = SCAN_IDX_W'(i);
      end
    end
  end

  assign hit_cat  = {grp_r, grp_hit_idx};
  assign free_cat = {grp_r, grp_free_idx};
  assign scan_end = grp_hit_found || (grp_r == GW'(NGRP - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_r       <= in_src_addr;
      now_r       <= in_now_seconds;
      ignore_r    <= in_ignore;
      hit_vec_r   <= hit_vec;
      free_vec_r  <= free_vec;
      grp_r       <= '0;
      free_seen_r <= 1'b0;
      hit_r       <= 1'b0;
      evict_r     <= 1'b0;
      slot_r      <= '0;
    end else if (cmd.scan_step) begin
      if (!free_seen_r && grp_free_found) begin
        free_seen_r <= 1'b1;
        free_slot_r <= free_cat[SW-1:0];
      end
      if (scan_end) begin
        if (grp_hit_found) begin
          hit_r  <= 1'b1;
          slot_r <= hit_cat[SW-1:0];
        end else if (free_seen_r) begin
          slot_r <= free_slot_r;
        end else if (grp_free_found) begin
          slot_r <= free_cat[SW-1:0];
        end else begin
          // table full: overwrite slot 0
          slot_r  <= '0;
          evict_r <= 1'b1;
        end
      end else begin
        grp_r <= grp_r + GW'(1);
      end
    end
  end

  // Entry RAM
  entry_t rd_entry, wr_entry;
  logic   ram_wr_en;

  ssw_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(slot_r),
    .wr_data(wr_entry),
    .rd_en  (cmd.rd_en),
    .rd_addr(slot_r),
    .rd_data(rd_entry)
  );

  // Window check, registered ahead of the count update
  logic [31:0] elapsed;
  logic        restart;
  logic [31:0] ws_new_r;
  logic [15:0] base_cnt_r;
  logic        base_al_r;

  assign elapsed = now_r - rd_entry.window_start;
  assign restart = elapsed > {16'd0, win_r};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ws_new_r   <= restart ? now_r : rd_entry.window_start;
      base_cnt_r <= restart ? 16'd0 : rd_entry.count;
      base_al_r  <= restart ? 1'b0 : rd_entry.alerted;
    end
  end

  // Count update
  logic [15:0] inc_cnt;
  logic        hit_alert;

  assign inc_cnt   = (base_cnt_r == COUNT_MAX) ? COUNT_MAX : base_cnt_r + 16'd1;
  assign hit_alert = (inc_cnt >= thr_r) && !base_al_r;

  always_comb begin
    if (hit_r) begin
      wr_entry.window_start = ws_new_r;
      wr_entry.count        = inc_cnt;
      wr_entry.alerted      = base_al_r || hit_alert;
    end else begin
      wr_entry.window_start = now_r;
      wr_entry.count        = 16'd1;
      wr_entry.alerted      = 1'b0;
    end
  end

  assign ram_wr_en = cmd.commit && !ignore_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !ignore_r && !hit_r) begin
      valid_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !ignore_r && !hit_r) begin
      addr_r[slot_r] <= src_r;
    end
  end

  // Result register
  logic        out_valid_r, out_alert_r, out_evicted_r;
  logic [15:0] out_count_r;
  logic [5:0]  out_slot_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (ignore_r) begin
        out_alert_r   <= 1'b0;
        out_count_r   <= 16'd0;
        out_slot_r    <= 6'd0;
        out_evicted_r <= 1'b0;
      end else if (hit_r) begin
        out_alert_r   <= hit_alert;
        out_count_r   <= inc_cnt;
        out_slot_r    <= 6'(slot_r);
        out_evicted_r <= 1'b0;
      end else begin
        out_alert_r   <= 1'b0;
        out_count_r   <= 16'd1;
        out_slot_r    <= 6'(slot_r);
        out_evicted_r <= evict_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scan_alert  = out_alert_r;
  assign out_burst_count = out_count_r;
  assign out_table_slot  = out_slot_r;
  assign out_evicted     = out_evicted_r;

  assign stat.in_ignore = in_ignore;
  assign stat.scan_end  = scan_end;
  assign stat.out_free  = out_free;

  `SSW_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, !out_valid_r || !out_stall)
  `SSW_ASSERT_IMP(a_evict_new, clk, rst_n, out_valid_r && out_evicted_r,
                  out_count_r == 16'd1 && !out_alert_r)
  `SSW_ASSERT_NXT(a_fill_valid, clk, rst_n, cmd.commit && !ignore_r, valid_r[slot_r])
  `SSW_ASSERT_IMP(a_alert_thr, clk, rst_n, out_valid_r && out_alert_r, out_count_r >= thr_r)

endmodule

### src/syn_scan_window_detector.sv
// Top level of the SYN-scan window detector: controller plus datapath.
//
//  channel  direction  handshake         payload
//  in       input      in_valid/stall    src_addr, tcp_flags, now_seconds
//  out      output     out_valid/stall   scan_alert, burst_count, table_slot, evicted
//  cfg      input      cfg_wr_en         cfg_index, cfg_data
//
// A SYN-only item is accepted in the idle state, then passes through the group scan,
// the RAM read, the window check and the update state before the next item is taken.
// The scan over the per-entry match vector walks 8-entry groups 0 to floor(slot/8) on
// a hit, all ceil(TABLE_ENTRIES/8) on a miss. Ignored items skip to the update state.
// Reset clears all valid marks at once; there is no clearing pass.
// A stalled result holds in the output register; the next item is still accepted
// and waits in its update cycle until the result register is free.
module syn_scan_window_detector import ssw_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_src_addr,
  input  logic [7:0]           in_tcp_flags,
  input  logic [31:0]          in_now_seconds,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_scan_alert,
  output logic [15:0]          out_burst_count,
  output logic [5:0]           out_table_slot,
  output logic                 out_evicted
);

  cmd_t  cmd;
  stat_t stat;

  ssw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  ssw_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_src_addr    (in_src_addr),
    .in_tcp_flags   (in_tcp_flags),
    .in_now_seconds (in_now_seconds),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_scan_alert (out_scan_alert),
    .out_burst_count(out_burst_count),
    .out_table_slot (out_table_slot),
    .out_evicted    (out_evicted),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the SYN-scan window detector.
`timescale 1ns / 100ps

module testbench;
  import ssw_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;
  localparam logic [7:0] SYN_FLAGS = 8'(1 << FLAG_SYN_BIT);
  localparam logic [7:0] ACK_FLAGS = 8'(1 << FLAG_ACK_BIT);

  typedef struct packed {
    logic        alert;
    logic [15:0] count;
    logic [5:0]  slot;
    logic        evicted;
  } scan_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [15:0]          cfg_data = 16'd0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_src_addr = 32'd0;
  logic [7:0]           in_tcp_flags = 8'd0;
  logic [31:0]          in_now_seconds = 32'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_scan_alert;
  logic [15:0]          out_burst_count;
  logic [5:0]           out_table_slot;
  logic                 out_evicted;

  // Predicted copy of the source table and registers.
  logic        src_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [31:0] src_addr_tab [TABLE_ENTRIES];
  logic [31:0] src_win_start [TABLE_ENTRIES];
  logic [15:0] src_count [TABLE_ENTRIES];
  logic        src_alerted [TABLE_ENTRIES];
  logic [15:0] win_len = WINDOW_RESET;
  logic [15:0] alert_level = THRESH_RESET;

  scan_result_t pending_results[$];
  scan_result_t seen, want;
  int          errors = 0;
  int          cycle_count = 0;
  logic        steady = 1'b0;
  logic        hold_go = 1'b0;
  logic [9:0]  hold_left = 10'd0;
  logic [31:0] clock_now = 32'd0;
  logic [31:0] hot_src [6];
  logic [31:0] wide_src [80];

  syn_scan_window_detector #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_src_addr(in_src_addr),
    .in_tcp_flags(in_tcp_flags),
    .in_now_seconds(in_now_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_scan_alert(out_scan_alert),
    .out_burst_count(out_burst_count),
    .out_table_slot(out_table_slot),
    .out_evicted(out_evicted)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    if (errors < 200)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // Update the source table for one packet and return the expected result.
  function automatic scan_result_t track_syn(input logic [31:0] addr, input logic [7:0] flags,
                                             input logic [31:0] now);
    scan_result_t r;
    int hit_slot;
    int free_slot;
    logic [31:0] elapsed;
    r = '0;
    hit_slot = -1;
    free_slot = -1;
    if (!flags[FLAG_SYN_BIT] || flags[FLAG_ACK_BIT])
      return r;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_slot < 0 && src_valid[i] && src_addr_tab[i] == addr)
        hit_slot = i;
      if (free_slot < 0 && !src_valid[i])
        free_slot = i;
    end
    if (hit_slot >= 0) begin
      elapsed = now - src_win_start[hit_slot];
      if (elapsed > {16'd0, win_len}) begin
        src_win_start[hit_slot] = now;
        src_count[hit_slot] = 16'd0;
        src_alerted[hit_slot] = 1'b0;
      end
      if (src_count[hit_slot] != COUNT_MAX)
        src_count[hit_slot] = src_count[hit_slot] + 16'd1;
      if (src_count[hit_slot] >= alert_level && !src_alerted[hit_slot]) begin
        src_alerted[hit_slot] = 1'b1;
        r.alert = 1'b1;
      end
      r.count = src_count[hit_slot];
      r.slot = 6'(hit_slot);
    end else begin
      // Full table: overwrite slot 0.
      if (free_slot < 0) begin
        free_slot = 0;
        r.evicted = 1'b1;
      end
      src_valid[free_slot] = 1'b1;
      src_addr_tab[free_slot] = addr;
      src_win_start[free_slot] = now;
      src_count[free_slot] = 16'd1;
      src_alerted[free_slot] = 1'b0;
      r.count = 16'd1;
      r.slot = 6'(free_slot);
    end
    return r;
  endfunction

  task automatic send_packet(input logic [31:0] addr, input logic [7:0] flags,
                             input logic [31:0] now);
    if (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_addr <= addr;
    in_tcp_flags <= flags;
    in_now_seconds <= now;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(track_syn(addr, flags, now));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_WINDOW: win_len = value;
      CFG_THRESH: alert_level = value;
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_go)
      hold_left <= 10'd300;
    else if (hold_left != 10'd0)
      hold_left <= hold_left - 10'd1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_scan_alert, out_burst_count, out_table_slot, out_evicted};
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %p with nothing pending", seen));
      end else begin
        want = pending_results.pop_front();
        if (seen.alert !== want.alert)
          note_mismatch($sformatf("scan_alert %b, want %b", seen.alert, want.alert));
        if (seen.count !== want.count)
          note_mismatch($sformatf("burst_count %0d, want %0d", seen.count, want.count));
        if (seen.slot !== want.slot)
          note_mismatch($sformatf("table_slot %0d, want %0d", seen.slot, want.slot));
        if (seen.evicted !== want.evicted)
          note_mismatch($sformatf("evicted %b, want %b", seen.evicted, want.evicted));
      end
    end
    out_stall <= (hold_left != 10'd0) || (!steady && $urandom_range(99) < 33);
  end

  task automatic test_directed();
    // Ignored packets at the field extremes.
    send_packet(32'h0000_0000, 8'h00, 32'h0000_0000);
    send_packet(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_packet(32'hFFFF_FFFF, SYN_FLAGS | ACK_FLAGS, 32'h0000_0000);
    send_packet(32'h0000_0000, ~SYN_FLAGS, 32'hFFFF_FFFF);
    // New entries, then hits at and past the window edge.
    send_packet(32'h0000_0000, SYN_FLAGS, 32'h0000_0000);
    send_packet(32'hFFFF_FFFF, ~ACK_FLAGS, 32'hFFFF_FFFF);
    send_packet(32'h0000_0000, SYN_FLAGS, 32'd60);
    send_packet(32'h0000_0000, SYN_FLAGS, 32'd121);
    // Time running backwards wraps to a large elapsed value.
    send_packet(32'h0000_0000, SYN_FLAGS, 32'd0);
    settle_block();
    // Threshold of one: a new entry stays quiet, the first hit alerts.
    write_reg(CFG_THRESH, 16'd1);
    write_reg(CFG_WINDOW, 16'd0);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd5);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd5);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd5);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd6);
    settle_block();
    // Unused register indexes must leave the window at zero.
    write_reg(CFG_THRESH, 16'd0);
    write_reg(CFG_SPARE2, 16'h0000);
    write_reg(CFG_SPARE3, 16'hFFFF);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd6);
    send_packet(32'h0A00_0001, SYN_FLAGS, 32'd7);
    send_packet(32'h0A00_0002, SYN_FLAGS, 32'd7);
    send_packet(32'h0A00_0002, SYN_FLAGS, 32'd7);
    settle_block();
    write_reg(CFG_WINDOW, WINDOW_RESET);
    write_reg(CFG_THRESH, THRESH_RESET);
  endtask

  task automatic test_random(input int n_items);
    int counted;
    int phase;
    int roll;
    logic [15:0] w;
    logic [15:0] t;
    logic [31:0] a;
    logic [7:0] f;
    counted = 0;
    phase = 0;
    while (counted < n_items) begin
      settle_block();
      case ($urandom_range(5))
        0: w = 16'd0;
        1: w = 16'd1;
        2: w = 16'($urandom_range(2, 10));
        3: w = 16'd60;
        4: w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: t = 16'd0;
        1: t = 16'd1;
        2: t = 16'($urandom_range(2, 6));
        3: t = 16'd20;
        4: t = 16'hFFFF;
        default: t = 16'($urandom);
      endcase
      write_reg(CFG_WINDOW, w);
      write_reg(CFG_THRESH, t);
      // One phase per call runs with no idling on either side.
      steady = (phase == 1);
      repeat (50) begin
        roll = $urandom_range(99);
        if (roll < 50)
          a = hot_src[$urandom_range(0, 5)];
        else if (roll < 90)
          a = wide_src[$urandom_range(0, 79)];
        else
          a = $urandom;
        f = 8'($urandom);
        if ($urandom_range(99) < 75) begin
          f[FLAG_SYN_BIT] = 1'b1;
          f[FLAG_ACK_BIT] = 1'b0;
        end
        roll = $urandom_range(99);
        if (roll < 4)
          clock_now = $urandom;
        else if (roll < 7)
          clock_now = clock_now - 32'($urandom_range(1, 5));
        else if (roll < 25)
          clock_now = clock_now + 32'($urandom_range(1, 3));
        send_packet(a, f, clock_now);
        counted++;
      end
      phase++;
    end
    settle_block();
    steady = 1'b0;
  endtask

  // Hold off the result side while items keep coming, then pause until drained.
  task automatic test_backpressure();
    steady = 1'b1;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (16) send_packet(hot_src[$urandom_range(0, 5)], SYN_FLAGS, clock_now);
    settle_block();
    steady = 1'b0;
  endtask

  // Fill every free slot, force evictions, then hit high slots.
  task automatic test_table_fill();
    write_reg(CFG_WINDOW, 16'd60);
    write_reg(CFG_THRESH, 16'd2);
    for (int i = 0; i < 70; i++)
      send_packet(32'hC0A8_0000 + 32'(i), SYN_FLAGS, clock_now);
    for (int i = 0; i < 8; i++)
      send_packet(32'hC0A8_0000 + 32'($urandom_range(40, 69)), SYN_FLAGS, clock_now);
    settle_block();
  endtask

  initial begin
    foreach (hot_src[i]) hot_src[i] = $urandom;
    foreach (wide_src[i]) wide_src[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_table_fill();
    test_random(250);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
